@@ hw/rtl/tcce_pkg.sv @@
// Shared types and constants for the text console cell engine.
`timescale 1ns / 1ps

package tcce_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  character;
    logic [10:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  cell_character;
    logic [7:0]  cell_attribute;
  } out_item_t;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BLANK     = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'd15;

  typedef enum logic [2:0] {
    K_GLYPH,
    K_NEWLINE,
    K_BACK,
    K_TAB,
    K_RETURN,
    K_READ,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_RET,
    CUR_NEXT_ROW,
    CUR_ADVANCE,
    CUR_BACK,
    CUR_PREV_ROW
  } cur_op_t;

  typedef enum logic [1:0] {
    WA_CURSOR,
    WA_PREV,
    WA_SWEEP
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_GLYPH,
    WD_BLANK,
    WD_RESET
  } wd_sel_t;

  typedef enum logic [1:0] {
    SW_BODY,
    SW_COPY,
    SW_LAST
  } sw_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    rd_item;
    logic    rd_sweep;
    logic    sweep_load;
    sw_sel_t sw_sel;
    logic    sweep_inc;
    logic    tab_dec;
    cur_op_t cur_op;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    kind_t kind;
    logic  col_zero;
    logic  col_last;
    logic  col_over;
    logic  row_top;
    logic  row_bottom;
    logic  tab_last;
    logic  sweep_last;
  } status_t;

endpackage

@@ hw/rtl/tcce_datapath.sv @@
// Datapath: cell memory, cursor, tab counter, sweep address and result fields.
`timescale 1ns / 1ps

module tcce_datapath #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int PINNED_ROWS = 2,
  parameter int TAB_STOP    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcce_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  tcce_pkg::cmd_t      cmd,
  output tcce_pkg::status_t   st,
  output tcce_pkg::out_item_t out_item
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS + 1);
  localparam int RW       = $clog2(ROWS);
  localparam int MW       = $clog2(TAB_STOP);
  localparam int TW       = $clog2(TAB_STOP + 1);
  localparam int MOD_LAST = (COLUMNS - 1) % TAB_STOP;

  localparam logic [AW-1:0] BODY_START = AW'(PINNED_ROWS * COLUMNS);
  localparam logic [AW-1:0] COPY_START = AW'((PINNED_ROWS + 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_START = AW'((ROWS - 1) * COLUMNS);

  function automatic tcce_pkg::kind_t decode_kind(tcce_pkg::in_item_t it);
    tcce_pkg::kind_t k;
    k = tcce_pkg::K_NOP;
    if (it.operation == tcce_pkg::OP_PUT) begin
      if (it.character == tcce_pkg::CH_NEWLINE) k = tcce_pkg::K_NEWLINE;
      else if (it.character == tcce_pkg::CH_BACKSPACE) k = tcce_pkg::K_BACK;
      else if (it.character == tcce_pkg::CH_TAB) k = tcce_pkg::K_TAB;
      else if (it.character == tcce_pkg::CH_RETURN) k = tcce_pkg::K_RETURN;
      else k = tcce_pkg::K_GLYPH;
    end else if (it.operation == tcce_pkg::OP_READ) begin
      k = tcce_pkg::K_READ;
    end else if (it.operation == tcce_pkg::OP_CLEAR) begin
      k = tcce_pkg::K_CLEAR;
    end
    return k;
  endfunction

  tcce_pkg::in_item_t item_r;
  tcce_pkg::kind_t    kind_r;
  logic [7:0]         attr_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [MW-1:0]      mod_r;
  logic [TW-1:0]      cnt_r;
  logic [AW-1:0]      sweep_r;
  logic               pend_r;
  logic [AW-1:0]      pend_addr_r;
  logic [15:0]        rd_data_r;
  logic [15:0]        mem [CELLS];

  logic [AW-1:0] cur_addr;
  logic          rd_ok;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [MW-1:0] mod_up;
  logic [MW-1:0] mod_down;

  assign cur_addr = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign rd_ok    = 32'(item_r.read_address) < 32'(CELLS);
  assign mod_up   = (mod_r == MW'(TAB_STOP - 1)) ? '0 : mod_r + MW'(1);
  assign mod_down = (mod_r == '0) ? MW'(TAB_STOP - 1) : mod_r - MW'(1);

  assign rd_en   = cmd.rd_sweep | (cmd.rd_item & rd_ok);
  assign rd_addr = cmd.rd_sweep ? sweep_r : AW'(item_r.read_address);

  always_comb begin
    wr_en   = cmd.wr_en | pend_r;
    wr_addr = cur_addr;
    wr_data = {attr_r, tcce_pkg::CH_BLANK};
    if (pend_r) begin
      wr_addr = pend_addr_r;
      wr_data = rd_data_r;
    end else begin
      unique case (cmd.wa_sel)
        tcce_pkg::WA_CURSOR: wr_addr = cur_addr;
        tcce_pkg::WA_PREV:   wr_addr = cur_addr - AW'(1);
        tcce_pkg::WA_SWEEP:  wr_addr = sweep_r;
        default:             wr_addr = cur_addr;
      endcase
      unique case (cmd.wd_sel)
        tcce_pkg::WD_GLYPH: wr_data = {attr_r, item_r.character};
        tcce_pkg::WD_BLANK: wr_data = {attr_r, tcce_pkg::CH_BLANK};
        tcce_pkg::WD_RESET: wr_data = {tcce_pkg::RESET_ATTR, tcce_pkg::CH_BLANK};
        default:            wr_data = {attr_r, tcce_pkg::CH_BLANK};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
      kind_r <= decode_kind(in_item);
      cnt_r  <= TW'(TAB_STOP) - TW'(mod_r);
    end else if (cmd.tab_dec) begin
      cnt_r <= cnt_r - TW'(1);
    end
    pend_addr_r <= sweep_r - AW'(COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r  <= tcce_pkg::RESET_ATTR;
      col_r   <= '0;
      row_r   <= RW'(PINNED_ROWS);
      mod_r   <= '0;
      sweep_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      pend_r <= cmd.rd_sweep;
      if (cmd.sweep_load) begin
        unique case (cmd.sw_sel)
          tcce_pkg::SW_BODY: sweep_r <= BODY_START;
          tcce_pkg::SW_COPY: sweep_r <= COPY_START;
          tcce_pkg::SW_LAST: sweep_r <= LAST_START;
          default:           sweep_r <= LAST_START;
        endcase
      end else if (cmd.sweep_inc) begin
        sweep_r <= sweep_r + AW'(1);
      end
      unique case (cmd.cur_op)
        tcce_pkg::CUR_HOLD: ;
        tcce_pkg::CUR_HOME: begin
          col_r <= '0;
          row_r <= RW'(PINNED_ROWS);
          mod_r <= '0;
        end
        tcce_pkg::CUR_RET: begin
          col_r <= '0;
          mod_r <= '0;
        end
        tcce_pkg::CUR_NEXT_ROW: begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
          mod_r <= '0;
        end
        tcce_pkg::CUR_ADVANCE: begin
          col_r <= col_r + CW'(1);
          mod_r <= mod_up;
        end
        tcce_pkg::CUR_BACK: begin
          col_r <= col_r - CW'(1);
          mod_r <= mod_down;
        end
        tcce_pkg::CUR_PREV_ROW: begin
          col_r <= CW'(COLUMNS - 1);
          row_r <= row_r - RW'(1);
          mod_r <= MW'(MOD_LAST);
        end
        default: ;
      endcase
    end
  end

  assign st.in_kind    = decode_kind(in_item);
  assign st.kind       = kind_r;
  assign st.col_zero   = (col_r == '0);
  assign st.col_last   = (col_r == CW'(COLUMNS - 1));
  assign st.col_over   = (col_r == CW'(COLUMNS));
  assign st.row_top    = (row_r == RW'(PINNED_ROWS));
  assign st.row_bottom = (row_r == RW'(ROWS - 1));
  assign st.tab_last   = (cnt_r == TW'(1));
  assign st.sweep_last = (sweep_r == AW'(CELLS - 1));

  always_comb begin
    out_item.cursor_position = 11'(cur_addr);
    out_item.cell_character  = '0;
    out_item.cell_attribute  = '0;
    if (kind_r == tcce_pkg::K_READ && rd_ok) begin
      out_item.cell_character = rd_data_r[7:0];
      out_item.cell_attribute = rd_data_r[15:8];
    end
  end

endmodule

@@ hw/rtl/tcce_ctrl.sv @@
// Controller: sequences item execution, tabs, scroll, clear and the reset fill.
`timescale 1ns / 1ps

module tcce_ctrl #(
  parameter int ROWS        = 25,
  parameter int PINNED_ROWS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  tcce_pkg::status_t st,
  output tcce_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_TAB,
    S_CLEAR,
    S_SCOPY,
    S_SDRAIN,
    S_SBLANK
  } state_t;

  localparam bit HAS_COPY = (PINNED_ROWS + 1) < ROWS;
  localparam state_t SCROLL_ENTRY = HAS_COPY ? S_SCOPY : S_SBLANK;
  localparam tcce_pkg::sw_sel_t SCROLL_SEL =
    HAS_COPY ? tcce_pkg::SW_COPY : tcce_pkg::SW_LAST;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = tcce_pkg::WA_SWEEP;
        cmd.wd_sel    = tcce_pkg::WD_RESET;
        cmd.sweep_inc = 1'b1;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          unique case (st.in_kind)
            tcce_pkg::K_TAB: state_nxt = S_TAB;
            tcce_pkg::K_CLEAR: begin
              cmd.sweep_load = 1'b1;
              cmd.sw_sel     = tcce_pkg::SW_BODY;
              state_nxt      = S_CLEAR;
            end
            default: state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
        unique case (st.kind)
          tcce_pkg::K_GLYPH: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = tcce_pkg::WA_CURSOR;
            cmd.wd_sel = tcce_pkg::WD_GLYPH;
            if (!st.col_last) begin
              cmd.cur_op = tcce_pkg::CUR_ADVANCE;
            end else if (!st.row_bottom) begin
              cmd.cur_op = tcce_pkg::CUR_NEXT_ROW;
            end else begin
              cmd.cur_op     = tcce_pkg::CUR_RET;
              cmd.sweep_load = 1'b1;
              cmd.sw_sel     = SCROLL_SEL;
              state_nxt      = SCROLL_ENTRY;
              done_nxt       = 1'b0;
            end
          end
          tcce_pkg::K_NEWLINE: begin
            if (!st.row_bottom) begin
              cmd.cur_op = tcce_pkg::CUR_NEXT_ROW;
            end else begin
              cmd.cur_op     = tcce_pkg::CUR_RET;
              cmd.sweep_load = 1'b1;
              cmd.sw_sel     = SCROLL_SEL;
              state_nxt      = SCROLL_ENTRY;
              done_nxt       = 1'b0;
            end
          end
          tcce_pkg::K_BACK: begin
            if (!(st.col_zero && st.row_top)) begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = tcce_pkg::WA_PREV;
              cmd.wd_sel = tcce_pkg::WD_BLANK;
              cmd.cur_op = st.col_zero ? tcce_pkg::CUR_PREV_ROW : tcce_pkg::CUR_BACK;
            end
          end
          tcce_pkg::K_RETURN: cmd.cur_op  = tcce_pkg::CUR_RET;
          tcce_pkg::K_READ:   cmd.rd_item = 1'b1;
          default: ;
        endcase
      end
      S_TAB: begin
        if (st.col_over) begin
          if (!st.row_bottom) begin
            cmd.cur_op = tcce_pkg::CUR_NEXT_ROW;
          end else begin
            cmd.cur_op     = tcce_pkg::CUR_RET;
            cmd.sweep_load = 1'b1;
            cmd.sw_sel     = SCROLL_SEL;
            state_nxt      = SCROLL_ENTRY;
          end
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = tcce_pkg::WA_CURSOR;
          cmd.wd_sel  = tcce_pkg::WD_BLANK;
          cmd.tab_dec = 1'b1;
          if (st.tab_last) begin
            // clamp at the last column instead of wrapping
            cmd.cur_op = st.col_last ? tcce_pkg::CUR_HOLD : tcce_pkg::CUR_ADVANCE;
            state_nxt  = S_IDLE;
            done_nxt   = 1'b1;
          end else begin
            cmd.cur_op = tcce_pkg::CUR_ADVANCE;
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = tcce_pkg::WA_SWEEP;
        cmd.wd_sel    = tcce_pkg::WD_BLANK;
        cmd.sweep_inc = 1'b1;
        if (st.sweep_last) begin
          cmd.cur_op = tcce_pkg::CUR_HOME;
          state_nxt  = S_IDLE;
          done_nxt   = 1'b1;
        end
      end
      S_SCOPY: begin
        cmd.rd_sweep = 1'b1;
        if (st.sweep_last) begin
          cmd.sweep_load = 1'b1;
          cmd.sw_sel     = tcce_pkg::SW_LAST;
          state_nxt      = S_SDRAIN;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_SDRAIN: state_nxt = S_SBLANK;
      S_SBLANK: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = tcce_pkg::WA_SWEEP;
        cmd.wd_sel    = tcce_pkg::WD_BLANK;
        cmd.sweep_inc = 1'b1;
        if (st.sweep_last) begin
          if (st.kind == tcce_pkg::K_TAB) begin
            state_nxt = S_TAB;
          end else begin
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

@@ hw/rtl/text_console_cell_engine_top.sv @@
// Top level of the text console cell engine.
`timescale 1ns / 1ps

// Usage:
//   Command channel: present in_item and raise start; the item transfers at
//   the rising edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_item;
//   the receiver cannot stall, so each result must be taken in that cycle.
//   Config: cfg_we with cfg_wdata writes the text attribute;
//   write it only while the block is idle.
// Operation:
//   Glyph, return, newline, backspace, read and unused operations run an
//   execute state on the cell memory, then a result cycle in which busy is
//   already low and the next item may transfer; at the bottom row a wrap or
//   newline scrolls first. Tab blanks cells up to the tab stop, wrapping to
//   the next row past the last column, then gives its result.
//   Scroll copies the unpinned rows below the first one up by one row, then
//   blanks the last row; clear blanks all unpinned rows and homes the cursor.
// Reset:
//   After rst_n the block sweeps all ROWS*COLUMNS cells to blank with
//   attribute 15, one cell a cycle, with busy high.
module text_console_cell_engine_top #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int PINNED_ROWS = 2,
  parameter int TAB_STOP    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tcce_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  tcce_pkg::cmd_t    cmd;
  tcce_pkg::status_t st;

  tcce_ctrl #(
    .ROWS        (ROWS),
    .PINNED_ROWS (PINNED_ROWS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .st    (st),
    .cmd   (cmd)
  );

  tcce_datapath #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .PINNED_ROWS (PINNED_ROWS),
    .TAB_STOP    (TAB_STOP)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_transfer_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start execution");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !cmd.wr_en)
    else $error("cell write while idle");
`endif

endmodule
